// ----- hdl/spas_pkg.sv -----
// Shared types and constants of the sprite animation sequencer.
`default_nettype none
package spas_pkg;

  localparam int START_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int FPR_W    = 11;
  localparam int PIXSZ_W  = 10;
  localparam int THRESH_W = 32;
  localparam int GAIN_W   = 16;
  localparam int MODE_W   = 2;

  localparam int ACTION_W = 2;
  localparam int DELTA_W  = 16;
  localparam int FRAME_W  = 10;
  localparam int PIXPOS_W = 20;
  localparam int IDX_W    = 11;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 56;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int MAX_SHEET_FRAMES = 1024;
  localparam int POS_LIMIT        = 1024;
  localparam int CNT_LIMIT_I      =
    (MAX_SHEET_FRAMES < POS_LIMIT) ? MAX_SHEET_FRAMES : POS_LIMIT;
  localparam logic [COUNT_W-1:0] CNT_LIMIT = COUNT_W'(CNT_LIMIT_I);

  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FPR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd7;

  localparam logic [THRESH_W-1:0] THRESH_RST = 32'd4266667;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd256;

  localparam int MUL_CYC  = DELTA_W;
  localparam int DIV_CYC  = IDX_W;
  localparam int PMUL_CYC = PIXSZ_W;
  localparam int CYC_W    = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_DIV,
    ST_PMUL,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/sprite_animation_sequencer_core.sv -----
// Sprite-sheet frame animator: timing accumulator, frame stepper and sheet position.
// A tick word passes through the serial gain multiply, the frame step, the restoring divider
// and the pixel multipliers; other words skip the multiply. A new word is accepted only
// once the previous word has been loaded into the output register.
// The result sits in an output register, so the next word is taken while it waits.
// Reset (synchronous, active high) loads the register defaults and clears all frame state.
`default_nettype none
module sprite_animation_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: action[1:0], delta_us[17:2], new_frame[27:18], zero fill
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [spas_pkg::S_TDATA_W-1:0]  s_tdata,
  // m_tdata: frame_pos[9:0], top[29:10], left[49:30], changed[50], finished[51], zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spas_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spas_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import spas_pkg::*;

  // Configuration registers.
  logic [START_W-1:0]  start_frame;
  logic [COUNT_W-1:0]  frame_count;
  logic [FPR_W-1:0]    frames_per_row;
  logic [PIXSZ_W-1:0]  frame_width;
  logic [PIXSZ_W-1:0]  frame_height;
  logic [THRESH_W-1:0] step_threshold;
  logic [GAIN_W-1:0]   rate_gain;
  logic [MODE_W-1:0]   mode;

  // Animation state.
  logic [THRESH_W-1:0] time_acc;
  logic [FRAME_W-1:0]  frame_pos;
  logic [FRAME_W-1:0]  last_frame;
  logic                last_valid;

  state_t              state, state_next;
  logic [CYC_W-1:0]    cnt;
  logic [ACTION_W-1:0] act_q;
  logic [FRAME_W-1:0]  tgt_q;

  logic [FRAME_W-1:0]  res_frame;
  logic                res_changed;
  logic                res_finished;
  logic [IDX_W-1:0]    quot;
  logic [IDX_W-1:0]    rem;

  logic                mul_load, mul_en, step_en, div_en, pmul_load, pmul_en, out_load;
  logic                cfg_wr;

  // Effective range and row width.
  logic [COUNT_W-1:0]  count;
  logic [FRAME_W-1:0]  count_m1;
  logic [FPR_W-1:0]    fpr;

  always_comb begin
    count = frame_count;
    if (frame_count == '0) begin
      count = COUNT_W'(1);
    end else if (frame_count > CNT_LIMIT) begin
      count = CNT_LIMIT;
    end
  end

  assign count_m1 = FRAME_W'(count - COUNT_W'(1));
  assign fpr      = (frames_per_row == '0) ? FPR_W'(1) : frames_per_row;

  // Serial gain by elapsed time product.
  logic [GAIN_W+DELTA_W-1:0] prod;

  spas_sermul #(.AW(GAIN_W), .BW(DELTA_W)) u_gain_mul (
    .clk  (clk),
    .load (mul_load),
    .en   (mul_en),
    .a    (rate_gain),
    .b    (s_tdata[ACTION_W +: DELTA_W]),
    .p    (prod)
  );

  // Frame update, computed combinationally and registered in the step state.
  logic [FRAME_W-1:0]  pos_c, pos_new;
  logic [THRESH_W:0]   acc_sum;
  logic [THRESH_W-1:0] acc_sat, acc_next;
  logic                lv_eff;
  logic                chg_new;
  logic [IDX_W-1:0]    idx_new;

  always_comb begin
    pos_c    = ({1'b0, frame_pos} >= count) ? count_m1 : frame_pos;
    acc_sum  = {1'b0, time_acc} + {1'b0, prod};
    acc_sat  = acc_sum[THRESH_W] ? {THRESH_W{1'b1}} : acc_sum[THRESH_W-1:0];
    acc_next = time_acc;
    pos_new  = pos_c;
    lv_eff   = last_valid;
    case (act_q)
      ACT_TICK: begin
        if (count > COUNT_W'(1)) begin
          acc_next = acc_sat;
          if (acc_sat > step_threshold) begin
            acc_next = '0;
            if (mode[1]) begin
              if (pos_c == '0) begin
                pos_new = mode[0] ? count_m1 : '0;
              end else begin
                pos_new = pos_c - FRAME_W'(1);
              end
            end else begin
              if (pos_c == count_m1) begin
                pos_new = mode[0] ? '0 : count_m1;
              end else begin
                pos_new = pos_c + FRAME_W'(1);
              end
            end
          end
        end
      end
      ACT_SET: begin
        pos_new = (tgt_q > count_m1) ? count_m1 : tgt_q;
      end
      ACT_RESTART: begin
        pos_new = mode[1] ? count_m1 : '0;
        lv_eff  = 1'b0;
      end
      default: begin
        pos_new = pos_c;
      end
    endcase
    chg_new = !lv_eff || (pos_new != last_frame);
    idx_new = {1'b0, start_frame} + {1'b0, pos_new};
  end

  // Restoring divider step: one quotient bit per cycle.
  logic [IDX_W:0]   div_r, div_d;
  logic             div_ge;
  logic [IDX_W-1:0] quot_next, rem_next;

  always_comb begin
    div_r     = {rem, quot[IDX_W-1]};
    div_d     = div_r - {1'b0, fpr};
    div_ge    = div_r >= {1'b0, fpr};
    rem_next  = div_ge ? div_d[IDX_W-1:0] : div_r[IDX_W-1:0];
    quot_next = {quot[IDX_W-2:0], div_ge};
  end

  // Pixel position products, loaded from the divider's final step.
  logic [IDX_W+PIXSZ_W-1:0] top_p, left_p;
  logic [PIXPOS_W-1:0]      top_sat, left_sat;

  spas_sermul #(.AW(IDX_W), .BW(PIXSZ_W)) u_top_mul (
    .clk  (clk),
    .load (pmul_load),
    .en   (pmul_en),
    .a    (quot_next),
    .b    (frame_height),
    .p    (top_p)
  );

  spas_sermul #(.AW(IDX_W), .BW(PIXSZ_W)) u_left_mul (
    .clk  (clk),
    .load (pmul_load),
    .en   (pmul_en),
    .a    (rem_next),
    .b    (frame_width),
    .p    (left_p)
  );

  assign top_sat  = (|top_p[IDX_W+PIXSZ_W-1:PIXPOS_W])  ? {PIXPOS_W{1'b1}} :
                                                          top_p[PIXPOS_W-1:0];
  assign left_sat = (|left_p[IDX_W+PIXSZ_W-1:PIXPOS_W]) ? {PIXPOS_W{1'b1}} :
                                                          left_p[PIXPOS_W-1:0];

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tdata[ACTION_W-1:0] == ACT_TICK) ? ST_MUL : ST_STEP;
        end
      end
      ST_MUL: begin
        if (cnt == CYC_W'(MUL_CYC - 1)) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CYC_W'(DIV_CYC - 1)) begin
          state_next = ST_PMUL;
        end
      end
      ST_PMUL: begin
        if (cnt == CYC_W'(PMUL_CYC - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready  = 1'b0;
    mul_load  = 1'b0;
    mul_en    = 1'b0;
    step_en   = 1'b0;
    div_en    = 1'b0;
    pmul_load = 1'b0;
    pmul_en   = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        mul_load = s_tvalid;
      end
      ST_MUL: begin
        mul_en = 1'b1;
      end
      ST_STEP: begin
        step_en = 1'b1;
      end
      ST_DIV: begin
        div_en    = 1'b1;
        pmul_load = (cnt == CYC_W'(DIV_CYC - 1));
      end
      ST_PMUL: begin
        pmul_en = 1'b1;
      end
      ST_OUT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Register writes are taken only between words, never during a frame update.
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CYC_W'(1);
    end
  end

  // Configuration and frame state share one process: a direction flip restarts.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame    <= '0;
      frame_count    <= COUNT_W'(1);
      frames_per_row <= FPR_W'(1);
      frame_width    <= '0;
      frame_height   <= '0;
      step_threshold <= THRESH_RST;
      rate_gain      <= GAIN_RST;
      mode           <= '0;
      time_acc       <= '0;
      frame_pos      <= '0;
      last_frame     <= '0;
      last_valid     <= 1'b0;
    end else if (step_en) begin
      time_acc   <= acc_next;
      frame_pos  <= pos_new;
      last_frame <= pos_new;
      last_valid <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_START:  start_frame    <= cfg_data[START_W-1:0];
        CFG_COUNT:  frame_count    <= cfg_data[COUNT_W-1:0];
        CFG_FPR:    frames_per_row <= cfg_data[FPR_W-1:0];
        CFG_WIDTH:  frame_width    <= cfg_data[PIXSZ_W-1:0];
        CFG_HEIGHT: frame_height   <= cfg_data[PIXSZ_W-1:0];
        CFG_THRESH: step_threshold <= cfg_data[THRESH_W-1:0];
        CFG_GAIN:   rate_gain      <= cfg_data[GAIN_W-1:0];
        CFG_MODE: begin
          mode <= cfg_data[MODE_W-1:0];
          if (cfg_data[1] != mode[1]) begin
            frame_pos  <= cfg_data[1] ? count_m1 : '0;
            last_valid <= 1'b0;
          end
        end
        default: begin
          mode <= mode;
        end
      endcase
    end
  end

  // Datapath registers of the current word.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act_q <= s_tdata[ACTION_W-1:0];
      tgt_q <= s_tdata[ACTION_W+DELTA_W +: FRAME_W];
    end
    if (step_en) begin
      res_frame    <= pos_new;
      res_changed  <= chg_new;
      res_finished <= (pos_new == count_m1);
      quot         <= idx_new;
      rem          <= '0;
    end else if (div_en) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(M_TDATA_W - FRAME_W - 2*PIXPOS_W - 2){1'b0}},
                  res_finished, res_changed, left_sat, top_sat, res_frame};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spas_sermul.sv -----
// Radix-2 shift-add multiplier that retires one multiplier bit per cycle while en is high.
`default_nettype none
module spas_sermul #(
  parameter int AW = 11,
  parameter int BW = 10
) (
  input  logic             clk,
  input  logic             load,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  logic [AW-1:0]    mcand;
  logic [AW+BW-1:0] acc;
  logic [AW:0]      psum;

  // The multiplier sits in the low bits and shifts out as the product grows in.
  assign psum = {1'b0, acc[AW+BW-1:BW]} + (acc[0] ? {1'b0, mcand} : {(AW+1){1'b0}});

  always_ff @(posedge clk) begin
    if (load) begin
      mcand <= a;
      acc   <= {{AW{1'b0}}, b};
    end else if (en) begin
      acc <= {psum, acc[BW-1:1]};
    end
  end

  assign p = acc;

endmodule
`default_nettype wire
